### rtl/ofs_pkg.sv
// Shared types, constants and register codes for the OFDM frame power scaler.
package ofs_pkg;

   // Sample and gain formats
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int FRAC_BITS = 12;
   localparam int PROD_W    = SAMPLE_W + GAIN_W;

   // Symbol geometry
   localparam int MAX_SYMBOL_LENGTH = 4096;
   localparam int LEN_W    = 13;
   localparam int SAMPLE_CNT_W = $clog2(MAX_SYMBOL_LENGTH);
   localparam int SYMBOL_CNT_W = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Unity gain in Q3.12, used for silence so it passes unchanged
   localparam logic signed [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << FRAC_BITS);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SYMBOL_LENGTH    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE_GAIN    = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PILOT_GAIN       = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_GAIN        = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE_SYMBOLS = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PILOT_SYMBOLS    = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_SYMBOLS     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SILENCE_SYMBOLS  = 4'd7;

   // Frame sections
   typedef enum logic [1:0] {
      SEC_PREAMBLE = 2'd0,
      SEC_PILOT    = 2'd1,
      SEC_DATA     = 2'd2,
      SEC_SILENCE  = 2'd3
   } section_type;

   // Configuration register set
   typedef struct packed {
      logic [LEN_W-1:0]         symbol_length;
      logic signed [GAIN_W-1:0] preamble_gain;
      logic signed [GAIN_W-1:0] pilot_gain;
      logic signed [GAIN_W-1:0] data_gain;
      logic [7:0]               preamble_symbols;
      logic [7:0]               pilot_symbols;
      logic [15:0]              data_symbols;
      logic [7:0]               silence_symbols;
   } cfg_type;

   // One classified sample travelling from front to back
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_re;
      logic signed [SAMPLE_W-1:0] sample_im;
      logic signed [GAIN_W-1:0]   gain;
      section_type                section;
      logic                       symbol_end;
   } entry_type;

endpackage

### rtl/ofs_front.sv
// Front part: frame section tracking, symbol counters and gain selection per sample.
module ofs_front
   import ofs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       accept,
   input  logic signed [SAMPLE_W-1:0] sample_re,
   input  logic signed [SAMPLE_W-1:0] sample_im,
   output entry_type                  entry
);

   section_type             frame_section_ff, frame_section_in;
   logic [SYMBOL_CNT_W-1:0] symbol_counter_ff, symbol_counter_in;
   logic [SAMPLE_CNT_W-1:0] sample_counter_ff, sample_counter_in;

   section_type             sec;
   logic [SYMBOL_CNT_W-1:0] sym_base;
   logic [LEN_W-1:0]        len_eff;
   logic                    sec_done;
   logic                    sym_end;

   // Symbols in a section; preamble and pilot never count as empty
   function automatic logic [SYMBOL_CNT_W-1:0] section_count(section_type s, cfg_type c);
      logic [SYMBOL_CNT_W-1:0] n;
      unique case (s)
         SEC_PREAMBLE: n = (c.preamble_symbols == 8'd0) ? SYMBOL_CNT_W'(1)
                                                        : SYMBOL_CNT_W'(c.preamble_symbols);
         SEC_PILOT:    n = (c.pilot_symbols == 8'd0) ? SYMBOL_CNT_W'(1)
                                                     : SYMBOL_CNT_W'(c.pilot_symbols);
         SEC_DATA:     n = c.data_symbols;
         SEC_SILENCE:  n = SYMBOL_CNT_W'(c.silence_symbols);
         default:      n = SYMBOL_CNT_W'(1);
      endcase
      return n;
   endfunction

   function automatic section_type next_section(section_type s);
      section_type n;
      unique case (s)
         SEC_PREAMBLE: n = SEC_PILOT;
         SEC_PILOT:    n = SEC_DATA;
         SEC_DATA:     n = SEC_SILENCE;
         SEC_SILENCE:  n = SEC_PREAMBLE;
         default:      n = SEC_PREAMBLE;
      endcase
      return n;
   endfunction

   // Section for this sample: end a finished section, then skip empty ones.
   // Only data and silence can be empty, so two skips reach preamble at worst.
   always_comb begin
      sec_done = symbol_counter_ff >= section_count(frame_section_ff, cfg);
      sec      = frame_section_ff;
      sym_base = symbol_counter_ff;
      if (sec_done) begin
         sec      = next_section(frame_section_ff);
         sym_base = '0;
         if (section_count(sec, cfg) == '0) sec = next_section(sec);
         if (section_count(sec, cfg) == '0) sec = next_section(sec);
      end
   end

   // Effective symbol length, clamped to 1..MAX_SYMBOL_LENGTH
   always_comb begin
      if (cfg.symbol_length == '0)
         len_eff = LEN_W'(1);
      else if (cfg.symbol_length > LEN_W'(MAX_SYMBOL_LENGTH))
         len_eff = LEN_W'(MAX_SYMBOL_LENGTH);
      else
         len_eff = cfg.symbol_length;
      sym_end = (LEN_W'(sample_counter_ff) + LEN_W'(1)) >= len_eff;
   end

   // Counter updates
   always_comb begin
      frame_section_in = sec;
      if (sym_end) begin
         sample_counter_in = '0;
         symbol_counter_in = sym_base + SYMBOL_CNT_W'(1);
      end else begin
         sample_counter_in = sample_counter_ff + SAMPLE_CNT_W'(1);
         symbol_counter_in = sym_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_section_ff  <= SEC_PREAMBLE;
         symbol_counter_ff <= '0;
         sample_counter_ff <= '0;
      end else if (accept) begin
         frame_section_ff  <= frame_section_in;
         symbol_counter_ff <= symbol_counter_in;
         sample_counter_ff <= sample_counter_in;
      end
   end

   // Classified beat toward the queue
   always_comb begin
      entry.sample_re  = sample_re;
      entry.sample_im  = sample_im;
      entry.section    = sec;
      entry.symbol_end = sym_end;
      case (sec)
         SEC_PREAMBLE: entry.gain = cfg.preamble_gain;
         SEC_PILOT:    entry.gain = cfg.pilot_gain;
         SEC_DATA:     entry.gain = cfg.data_gain;
         default:      entry.gain = UNITY_GAIN;
      endcase
   end

endmodule

### rtl/ofs_queue.sv
// Short queue of classified beats between front and back.
module ofs_queue
   import ofs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type         mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   logic do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_entry;
   end

   // Pointers and fill count; pointers wrap at the power-of-two depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)   wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (push && !do_pop)      count_ff <= count_ff + QCNT_W'(1);
         else if (!push && do_pop) count_ff <= count_ff - QCNT_W'(1);
      end
   end

endmodule

### rtl/ofs_back.sv
// Back part: gain multiply, round-half-up and saturation, with the output register.
module ofs_back
   import ofs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  entry_type                  head_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_scaled_re,
   output logic signed [SAMPLE_W-1:0] rsp_scaled_im,
   output logic [1:0]                 rsp_section,
   output logic                       rsp_symbol_end
);

   localparam int RND_W = PROD_W + 1;
   localparam int Q_W   = RND_W - FRAC_BITS;
   localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [Q_W-1:0]   Q_MIN = -Q_MAX - Q_W'(1);

   logic                     a_valid_ff;
   logic signed [PROD_W-1:0] prod_re_ff, prod_re_in;
   logic signed [PROD_W-1:0] prod_im_ff, prod_im_in;
   section_type              a_section_ff;
   logic                     a_end_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] scaled_re_ff, scaled_re_in;
   logic signed [SAMPLE_W-1:0] scaled_im_ff, scaled_im_in;
   section_type                section_ff;
   logic                       symbol_end_ff;

   logic out_free;
   logic a_en;

   // Add half an LSB, floor shift, clamp to the sample range
   function automatic logic signed [SAMPLE_W-1:0] round_sat(logic signed [PROD_W-1:0] p);
      logic signed [RND_W-1:0] sum;
      logic signed [Q_W-1:0]   q;
      logic signed [SAMPLE_W-1:0] r;
      sum = {p[PROD_W-1], p} + ROUND_BIAS;
      q   = sum[RND_W-1:FRAC_BITS];
      if (q > Q_MAX)
         r = Q_MAX[SAMPLE_W-1:0];
      else if (q < Q_MIN)
         r = Q_MIN[SAMPLE_W-1:0];
      else
         r = q[SAMPLE_W-1:0];
      return r;
   endfunction

   // Pipeline advance
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign a_en     = !a_valid_ff || out_free;
   assign pop      = a_en && head_valid;

   always_comb begin
      prod_re_in   = head_entry.sample_re * head_entry.gain;
      prod_im_in   = head_entry.sample_im * head_entry.gain;
      scaled_re_in = round_sat(prod_re_ff);
      scaled_im_in = round_sat(prod_im_ff);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_en)     a_valid_ff   <= head_valid;
         if (out_free) rsp_valid_ff <= a_valid_ff;
      end
   end

   // Payload: product stage, then output register
   always_ff @(posedge clock) begin
      if (a_en) begin
         prod_re_ff   <= prod_re_in;
         prod_im_ff   <= prod_im_in;
         a_section_ff <= head_entry.section;
         a_end_ff     <= head_entry.symbol_end;
      end
      if (out_free) begin
         scaled_re_ff  <= scaled_re_in;
         scaled_im_ff  <= scaled_im_in;
         section_ff    <= a_section_ff;
         symbol_end_ff <= a_end_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scaled_re  = scaled_re_ff;
   assign rsp_scaled_im  = scaled_im_ff;
   assign rsp_section    = section_ff;
   assign rsp_symbol_end = symbol_end_ff;

endmodule

### rtl/ofdm_frame_power_scaler_unit.sv
// Top level of the OFDM frame power scaler: configuration registers, front, queue and back.
//
// Scales a stream of complex samples by the gain of the frame section each sample falls in
// (preamble, pilot, data; silence passes unchanged), with round-half-up and saturation to 16
// bits, and tags every result with its section and an end-of-symbol flag. One sample is
// accepted and one result delivered per clock when the output side does not stall. A result
// is offered once its sample has passed the queue write at the accepting edge, the product
// register and the output register. A four-beat queue decouples the front from the multiply
// pipeline, so req_stall rises only once four beats are waiting behind a stalled output.
// Configuration writes take effect at once and should be made only while no samples are in
// flight.
module ofdm_frame_power_scaler_unit
   import ofs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_re,
   input  logic signed [SAMPLE_W-1:0] req_sample_im,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_scaled_re,
   output logic signed [SAMPLE_W-1:0] rsp_scaled_im,
   output logic [1:0]                 rsp_section,
   output logic                       rsp_symbol_end,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   cfg_type   cfg_ff;
   logic      accept;
   logic      q_full;
   logic      q_pop;
   logic      q_head_valid;
   entry_type front_entry;
   entry_type q_head_entry;

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.symbol_length    <= LEN_W'(64);
         cfg_ff.preamble_gain    <= UNITY_GAIN;
         cfg_ff.pilot_gain       <= UNITY_GAIN;
         cfg_ff.data_gain        <= UNITY_GAIN;
         cfg_ff.preamble_symbols <= 8'd1;
         cfg_ff.pilot_symbols    <= 8'd1;
         cfg_ff.data_symbols     <= 16'd1;
         cfg_ff.silence_symbols  <= 8'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SYMBOL_LENGTH:    cfg_ff.symbol_length    <= csr_wdata[LEN_W-1:0];
            REG_PREAMBLE_GAIN:    cfg_ff.preamble_gain    <= csr_wdata[GAIN_W-1:0];
            REG_PILOT_GAIN:       cfg_ff.pilot_gain       <= csr_wdata[GAIN_W-1:0];
            REG_DATA_GAIN:        cfg_ff.data_gain        <= csr_wdata[GAIN_W-1:0];
            REG_PREAMBLE_SYMBOLS: cfg_ff.preamble_symbols <= csr_wdata[7:0];
            REG_PILOT_SYMBOLS:    cfg_ff.pilot_symbols    <= csr_wdata[7:0];
            REG_DATA_SYMBOLS:     cfg_ff.data_symbols     <= csr_wdata[15:0];
            REG_SILENCE_SYMBOLS:  cfg_ff.silence_symbols  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Input handshake
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   ofs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .sample_re (req_sample_re),
      .sample_im (req_sample_im),
      .entry     (front_entry)
   );

   ofs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   ofs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_head_valid),
      .head_entry     (q_head_entry),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scaled_re  (rsp_scaled_re),
      .rsp_scaled_im  (rsp_scaled_im),
      .rsp_section    (rsp_section),
      .rsp_symbol_end (rsp_symbol_end)
   );

endmodule

### rtl/ofs_checker.sv
// Port-level checks for the OFDM frame power scaler, bound to the top level.
module ofs_checker
   import ofs_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic signed [SAMPLE_W-1:0] req_sample_re,
   input logic signed [SAMPLE_W-1:0] req_sample_im,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_scaled_re,
   input logic signed [SAMPLE_W-1:0] rsp_scaled_im,
   input logic [1:0]                 rsp_section,
   input logic                       rsp_symbol_end,
   input logic                       csr_write,
   input logic [CSR_INDEX_W-1:0]     csr_index,
   input logic [CSR_DATA_W-1:0]      csr_wdata
);

   logic       last_valid_ff;
   logic [1:0] last_section_ff;
   logic       last_end_ff;
   logic       rsp_beat;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // Track the last delivered beat; a config write starts over
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         last_valid_ff <= 1'b0;
      end else if (rsp_beat) begin
         last_valid_ff   <= 1'b1;
         last_section_ff <= rsp_section;
         last_end_ff     <= rsp_symbol_end;
      end
   end

   // Reset leaves the output empty and the input open
   a_reset_clean: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("output valid or input stall after reset");

   // Section can only change on a symbol boundary
   a_section_on_boundary: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && last_valid_ff && !last_end_ff |-> rsp_section == last_section_ff)
      else $error("section changed in the middle of a symbol");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_scaled_re) && $stable(rsp_scaled_im)
                               && $stable(rsp_section) && $stable(rsp_symbol_end))
      else $error("result payload changed while stalled");

endmodule

bind ofdm_frame_power_scaler_unit ofs_checker u_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the OFDM frame power scaler: frame predictor, stimulus and checks.
`timescale 1ns / 100ps

module testbench;
   import ofs_pkg::*;

   localparam int     ITEM_TARGET   = 1600;
   localparam int     CYCLE_LIMIT   = 400000;
   localparam int     TAIL_CYCLES   = 8;
   localparam longint SAMPLE_MAX    = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN    = -SAMPLE_MAX - 1;
   localparam longint ROUND_HALF    = longint'(1) << (FRAC_BITS - 1);
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED_FIRST = 4'd8;

   // One expected output beat
   typedef struct {
      logic signed [SAMPLE_W-1:0] scaled_re;
      logic signed [SAMPLE_W-1:0] scaled_im;
      section_type                section;
      logic                       symbol_end;
   } scaled_sample_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_re = '0;
   logic signed [SAMPLE_W-1:0] req_sample_im = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_scaled_re;
   logic signed [SAMPLE_W-1:0] rsp_scaled_im;
   logic [1:0]                 rsp_section;
   logic                       rsp_symbol_end;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // Predictor state: register copy and frame position
   cfg_type                    frame_cfg;
   section_type                cur_section;
   logic [SYMBOL_CNT_W-1:0]    symbol_count;
   int unsigned                sample_index;
   scaled_sample_type          pending_scaled_q[$];

   // Bookkeeping
   int unsigned                error_count = 0;
   int unsigned                samples_sent = 0;
   int unsigned                csr_writes = 0;
   int unsigned                section_hits[4] = '{0, 0, 0, 0};
   int unsigned                symbol_ends_seen = 0;
   int unsigned                cycle_count = 0;
   int unsigned                burst_left = 0;
   int unsigned                gap_max = 0;

   ofdm_frame_power_scaler_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_re  (req_sample_re),
      .req_sample_im  (req_sample_im),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scaled_re  (rsp_scaled_re),
      .rsp_scaled_im  (rsp_scaled_im),
      .rsp_section    (rsp_section),
      .rsp_symbol_end (rsp_symbol_end),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still pending", cycle_count,
                  pending_scaled_q.size());
         $display("ofdm_frame_power_scaler_unit regression: fail");
         $finish;
      end
   end

   // Output stall pattern: free, light, heavy and long-streak modes
   int unsigned stall_mode = 0;
   int unsigned mode_left = 0;
   int unsigned streak_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (streak_left == 0) begin
               streak_left <= $urandom_range(1, 12);
               rsp_stall   <= ~rsp_stall;
            end else begin
               streak_left <= streak_left - 1;
            end
         end
      endcase
   end

   // Symbol count of a section; preamble and pilot never go below one
   function automatic int unsigned section_symbol_count(section_type sec);
      case (sec)
         SEC_PREAMBLE: return (frame_cfg.preamble_symbols == 0) ? 1 : frame_cfg.preamble_symbols;
         SEC_PILOT:    return (frame_cfg.pilot_symbols == 0) ? 1 : frame_cfg.pilot_symbols;
         SEC_DATA:     return frame_cfg.data_symbols;
         default:      return frame_cfg.silence_symbols;
      endcase
   endfunction

   // Q3.12 multiply, round half up, saturate to the sample range
   function automatic logic signed [SAMPLE_W-1:0] apply_section_gain(
      logic signed [SAMPLE_W-1:0] sample, logic signed [GAIN_W-1:0] gain);
      longint prod;
      prod = (longint'(sample) * longint'(gain) + ROUND_HALF) >>> FRAC_BITS;
      if (prod > SAMPLE_MAX) prod = SAMPLE_MAX;
      if (prod < SAMPLE_MIN) prod = SAMPLE_MIN;
      return prod[SAMPLE_W-1:0];
   endfunction

   // Advance the frame by one accepted sample and queue the expected beat
   function automatic void predict_frame_sample(logic signed [SAMPLE_W-1:0] re,
                                                logic signed [SAMPLE_W-1:0] im);
      scaled_sample_type want;
      int unsigned    len;
      int             k;
      logic signed [GAIN_W-1:0] gain;
      // close finished or empty sections first
      for (k = 0; k < 4 && symbol_count >= section_symbol_count(cur_section); k++) begin
         cur_section  = section_type'(2'(cur_section + 1));
         symbol_count = '0;
      end
      len = frame_cfg.symbol_length;
      if (len == 0) len = 1;
      if (len > MAX_SYMBOL_LENGTH) len = MAX_SYMBOL_LENGTH;
      case (cur_section)
         SEC_PREAMBLE: gain = frame_cfg.preamble_gain;
         SEC_PILOT:    gain = frame_cfg.pilot_gain;
         default:      gain = frame_cfg.data_gain;
      endcase
      if (cur_section == SEC_SILENCE) begin
         want.scaled_re = re;
         want.scaled_im = im;
      end else begin
         want.scaled_re = apply_section_gain(re, gain);
         want.scaled_im = apply_section_gain(im, gain);
      end
      want.section    = cur_section;
      want.symbol_end = (sample_index + 1 >= len);
      if (want.symbol_end) begin
         sample_index = 0;
         symbol_count = symbol_count + 1'b1;
      end else begin
         sample_index = sample_index + 1;
      end
      pending_scaled_q.push_back(want);
   endfunction

   // Result checker
   always @(posedge clock) begin
      scaled_sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scaled_q.size() == 0) begin
            $error("output beat with nothing expected: re %0d im %0d section %0d",
                   rsp_scaled_re, rsp_scaled_im, rsp_section);
            error_count++;
         end else begin
            want = pending_scaled_q.pop_front();
            if (rsp_scaled_re !== want.scaled_re) begin
               $error("scaled_re: expected %0d, got %0d", want.scaled_re, rsp_scaled_re);
               error_count++;
            end
            if (rsp_scaled_im !== want.scaled_im) begin
               $error("scaled_im: expected %0d, got %0d", want.scaled_im, rsp_scaled_im);
               error_count++;
            end
            if (rsp_section !== want.section) begin
               $error("section: expected %0d, got %0d", want.section, rsp_section);
               error_count++;
            end
            if (rsp_symbol_end !== want.symbol_end) begin
               $error("symbol_end: expected %0d, got %0d", want.symbol_end, rsp_symbol_end);
               error_count++;
            end
            section_hits[want.section]++;
            if (want.symbol_end) symbol_ends_seen++;
         end
      end
   end

   // Stop sending and let every expected beat come out
   task automatic wait_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_scaled_q.size() != 0) @(posedge clock);
   endtask

   // Register write, only with the pipe empty; strobe is lowered by the next send
   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         REG_SYMBOL_LENGTH:    frame_cfg.symbol_length    = data[LEN_W-1:0];
         REG_PREAMBLE_GAIN:    frame_cfg.preamble_gain    = data;
         REG_PILOT_GAIN:       frame_cfg.pilot_gain       = data;
         REG_DATA_GAIN:        frame_cfg.data_gain        = data;
         REG_PREAMBLE_SYMBOLS: frame_cfg.preamble_symbols = data[7:0];
         REG_PILOT_SYMBOLS:    frame_cfg.pilot_symbols    = data[7:0];
         REG_DATA_SYMBOLS:     frame_cfg.data_symbols     = data;
         REG_SILENCE_SYMBOLS:  frame_cfg.silence_symbols  = data[7:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Send one sample beat, with burst/gap idling in front of it
   task automatic send_sample(logic signed [SAMPLE_W-1:0] re, logic signed [SAMPLE_W-1:0] im);
      int unsigned gap;
      csr_write <= 1'b0;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_sample_re <= re;
      req_sample_im <= im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame_sample(re, im);
      samples_sent++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         4: return 16'sh0001;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return UNITY_GAIN;
         4: return -UNITY_GAIN;
         default: return CSR_DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Reset values, extreme samples at unity preamble gain
   task automatic test_reset_defaults();
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sh0000, 16'shFFFF);
      send_sample(16'sh0001, 16'sh5A5A);
   endtask

   // Saturation at both rails, then round-half-up at gain one half, through all four sections
   task automatic test_gain_extremes();
      write_register(REG_SYMBOL_LENGTH, 16'd1);
      write_register(REG_SILENCE_SYMBOLS, 16'd1);
      write_register(REG_PREAMBLE_GAIN, 16'h7FFF);
      write_register(REG_PILOT_GAIN, 16'h8000);
      write_register(REG_DATA_GAIN, 16'h7FFF);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sh7FFF, 16'sh8000);
      send_sample(16'sh8000, 16'sh7FFF);
      write_register(REG_PREAMBLE_GAIN, 16'd2048);
      write_register(REG_PILOT_GAIN, 16'd2048);
      write_register(REG_DATA_GAIN, 16'd2048);
      send_sample(16'sh0001, 16'shFFFF);
      send_sample(16'sh0003, 16'shFFFD);
      send_sample(16'shFFFF, 16'sh0001);
      send_sample(16'shFFFD, 16'sh0003);
   endtask

   // Zero counts: preamble and pilot act as one symbol, data and silence are skipped
   task automatic test_zero_counts();
      write_register(REG_SYMBOL_LENGTH, 16'd2);
      write_register(REG_PREAMBLE_SYMBOLS, 16'd0);
      write_register(REG_PILOT_SYMBOLS, 16'd0);
      write_register(REG_DATA_SYMBOLS, 16'd0);
      write_register(REG_SILENCE_SYMBOLS, 16'd0);
      repeat (5) send_sample(pick_sample(), pick_sample());
   endtask

   // Length zero, length above the maximum, length lowered mid-symbol, masked upper bits
   task automatic test_symbol_length_edges();
      write_register(REG_SYMBOL_LENGTH, 16'd0);
      repeat (2) send_sample(pick_sample(), pick_sample());
      write_register(REG_SYMBOL_LENGTH, 16'h1FFF);
      repeat (4) send_sample(pick_sample(), pick_sample());
      write_register(REG_SYMBOL_LENGTH, 16'd3);
      send_sample(pick_sample(), pick_sample());
      write_register(REG_SYMBOL_LENGTH, 16'hE002);
      repeat (2) send_sample(pick_sample(), pick_sample());
   endtask

   // Data count lowered below the symbols already done in the data section
   task automatic test_counts_lowered();
      write_register(REG_SYMBOL_LENGTH, 16'd1);
      write_register(REG_PREAMBLE_SYMBOLS, 16'd1);
      write_register(REG_PILOT_SYMBOLS, 16'd1);
      write_register(REG_DATA_SYMBOLS, 16'd6);
      write_register(REG_SILENCE_SYMBOLS, 16'd1);
      while (!(cur_section == SEC_DATA && symbol_count == 3))
         send_sample(pick_sample(), pick_sample());
      write_register(REG_DATA_SYMBOLS, 16'd2);
      repeat (2) send_sample(pick_sample(), pick_sample());
   endtask

   // Writes to indexes past the register map must change nothing
   task automatic test_unmapped_index();
      write_register(REG_UNMAPPED_FIRST, 16'hFFFF);
      write_register(CSR_INDEX_W'(REG_UNMAPPED_FIRST + $urandom_range(1, 7)),
                     CSR_DATA_W'($urandom));
      repeat (2) send_sample(pick_sample(), pick_sample());
   endtask

   // Random frame settings per phase, random samples, varied idling
   task automatic test_random_frames();
      int unsigned start_count;
      int unsigned phase_items;
      start_count = samples_sent;
      while (samples_sent - start_count < ITEM_TARGET) begin
         // new frame setting between phases; state carries over on purpose
         if ($urandom_range(0, 1))
            write_register(REG_SYMBOL_LENGTH, ($urandom_range(0, 9) == 0) ?
                           CSR_DATA_W'($urandom_range(0, 65535)) :
                           CSR_DATA_W'($urandom_range(0, 6)));
         if ($urandom_range(0, 1)) write_register(REG_PREAMBLE_GAIN, pick_gain());
         if ($urandom_range(0, 1)) write_register(REG_PILOT_GAIN, pick_gain());
         if ($urandom_range(0, 1)) write_register(REG_DATA_GAIN, pick_gain());
         if ($urandom_range(0, 2) == 0)
            write_register(REG_PREAMBLE_SYMBOLS, ($urandom_range(0, 7) == 0) ?
                           CSR_DATA_W'($urandom_range(0, 65535)) :
                           CSR_DATA_W'($urandom_range(0, 3)));
         if ($urandom_range(0, 2) == 0)
            write_register(REG_PILOT_SYMBOLS, ($urandom_range(0, 7) == 0) ?
                           CSR_DATA_W'($urandom_range(0, 65535)) :
                           CSR_DATA_W'($urandom_range(0, 3)));
         if ($urandom_range(0, 2) == 0)
            write_register(REG_DATA_SYMBOLS, ($urandom_range(0, 15) == 0) ?
                           CSR_DATA_W'($urandom_range(0, 65535)) :
                           CSR_DATA_W'($urandom_range(0, 4)));
         if ($urandom_range(0, 2) == 0)
            write_register(REG_SILENCE_SYMBOLS, ($urandom_range(0, 7) == 0) ? 16'd255 :
                           CSR_DATA_W'($urandom_range(0, 3)));
         if ($urandom_range(0, 15) == 0)
            write_register(CSR_INDEX_W'(REG_UNMAPPED_FIRST + $urandom_range(0, 7)),
                           CSR_DATA_W'($urandom_range(0, 65535)));
         case ($urandom_range(0, 3))
            0, 1: gap_max = 0;
            2:    gap_max = 3;
            default: gap_max = 8;
         endcase
         phase_items = $urandom_range(10, 60);
         repeat (phase_items) send_sample(pick_sample(), pick_sample());
      end
   endtask

   // Test sequence
   initial begin
      frame_cfg.symbol_length    = LEN_W'(64);
      frame_cfg.preamble_gain    = UNITY_GAIN;
      frame_cfg.pilot_gain       = UNITY_GAIN;
      frame_cfg.data_gain        = UNITY_GAIN;
      frame_cfg.preamble_symbols = 8'd1;
      frame_cfg.pilot_symbols    = 8'd1;
      frame_cfg.data_symbols     = 16'd1;
      frame_cfg.silence_symbols  = 8'd0;
      cur_section  = SEC_PREAMBLE;
      symbol_count = '0;
      sample_index = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_max = 2;
      test_reset_defaults();
      test_gain_extremes();
      test_zero_counts();
      test_symbol_length_edges();
      test_counts_lowered();
      test_unmapped_index();
      test_random_frames();

      wait_drained();
      csr_write <= 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d samples sent across %0d register writes, %0d symbol ends seen",
               samples_sent, csr_writes, symbol_ends_seen);
      $display("beats per section: preamble %0d, pilot %0d, data %0d, silence %0d",
               section_hits[SEC_PREAMBLE], section_hits[SEC_PILOT],
               section_hits[SEC_DATA], section_hits[SEC_SILENCE]);
      if (error_count == 0 && pending_scaled_q.size() == 0) begin
         $display("ofdm_frame_power_scaler_unit regression: pass");
      end else begin
         if (pending_scaled_q.size() != 0)
            $error("%0d expected beats never arrived", pending_scaled_q.size());
         $display("ofdm_frame_power_scaler_unit regression: fail");
      end
      $finish;
   end

endmodule

### ofdm_frame_power_scaler_unit.f
rtl/ofs_pkg.sv
rtl/ofs_front.sv
rtl/ofs_queue.sv
rtl/ofs_back.sv
rtl/ofdm_frame_power_scaler_unit.sv
rtl/ofs_checker.sv
tb/sv/testbench.sv
